// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dcpc_pkg.sv
// ----------------------------------------------------------------------------
// dcpc_pkg
// Types and constants for the daisy-chain PEC-15 readback checker.
// ----------------------------------------------------------------------------
package dcpc_pkg;

  localparam int DATA_BYTES = 6;
  localparam int DATA_W     = 8 * DATA_BYTES;
  localparam int POS_W      = 3;
  localparam int SEG_W      = 4;

  localparam logic [15:0] PEC_POLY = 16'h4599;
  localparam logic [15:0] PEC_SEED = 16'd16;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [2:0]        device_index;
    logic [DATA_W-1:0] data_word;
    logic              pec_ok;
    logic              frame_ok;
    logic              last_segment;
  } out_t;

endpackage

// File: hw/rtl/dcpc_pec15.sv
// ----------------------------------------------------------------------------
// dcpc_pec15
// Byte-wide PEC-15 remainder update, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module dcpc_pec15
  import dcpc_pkg::*;
(
  input  logic [15:0] rem,
  input  logic [7:0]  data,
  output logic [15:0] rem_upd
);

  logic [15:0] v;

  always_comb begin
    v = {1'b0, (rem[14:7] ^ data), 7'b0};
    for (int i = 0; i < 8; i++) begin
      if (v[14]) begin
        v = {v[14:0], 1'b0} ^ PEC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    rem_upd = {rem[7:0], 8'b0} ^ v;
  end

endmodule

// File: hw/rtl/dcpc_seg_tracker.sv
// ----------------------------------------------------------------------------
// dcpc_seg_tracker
// Segment and frame state, PEC comparison and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcpc_seg_tracker
  import dcpc_pkg::*;
#(
  parameter int NUM_DEVICES = 2
)
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  in_t  item,
  output logic res_valid,
  input  logic res_ready,
  output out_t res_data
);

  logic [POS_W-1:0]  byte_position, byte_position_next, pos_e;
  logic [SEG_W-1:0]  segment_count, segment_count_next, seg_e;
  logic [15:0]       running_remainder, running_remainder_next, rem_e, rem_upd;
  logic [DATA_W-1:0] data_shift, data_shift_next, shift_e;
  logic [7:0]        pec_high_byte, pec_high_byte_next, hi_e;
  logic              all_good, all_good_next, good_e;
  logic              fire, frame_done, pec_ok, emit;
  out_t              res_next;

  assign item_ready = !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  // A frame start byte sees the reset state before it is used.
  always_comb begin
    if (item.frame_start) begin
      pos_e   = '0;
      seg_e   = '0;
      rem_e   = PEC_SEED;
      shift_e = '0;
      hi_e    = '0;
      good_e  = 1'b1;
    end else begin
      pos_e   = byte_position;
      seg_e   = segment_count;
      rem_e   = running_remainder;
      shift_e = data_shift;
      hi_e    = pec_high_byte;
      good_e  = all_good;
    end
  end

  dcpc_pec15 u_pec15 (
    .rem     (rem_e),
    .data    (item.rx_byte),
    .rem_upd (rem_upd)
  );

  assign frame_done = seg_e >= SEG_W'(NUM_DEVICES);
  assign pec_ok     = {hi_e, item.rx_byte} == {rem_e[14:0], 1'b0};

  always_comb begin
    byte_position_next     = pos_e;
    segment_count_next     = seg_e;
    running_remainder_next = rem_e;
    data_shift_next        = shift_e;
    pec_high_byte_next     = hi_e;
    all_good_next          = good_e;
    emit                   = 1'b0;

    res_next.device_index  = seg_e[2:0];
    res_next.data_word     = shift_e;
    res_next.pec_ok        = pec_ok;
    res_next.frame_ok      = good_e && pec_ok;
    res_next.last_segment  = seg_e == SEG_W'(NUM_DEVICES - 1);

    if (!frame_done) begin
      if (pos_e < POS_W'(DATA_BYTES)) begin
        running_remainder_next = rem_upd;
        data_shift_next[{pos_e, 3'b000} +: 8] = item.rx_byte;
        byte_position_next = pos_e + 1'b1;
      end else if (pos_e == POS_W'(DATA_BYTES)) begin
        pec_high_byte_next = item.rx_byte;
        byte_position_next = pos_e + 1'b1;
      end else begin
        emit                   = 1'b1;
        all_good_next          = good_e && pec_ok;
        segment_count_next     = seg_e + 1'b1;
        byte_position_next     = '0;
        running_remainder_next = PEC_SEED;
        data_shift_next        = '0;
        pec_high_byte_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      segment_count     <= '0;
      running_remainder <= PEC_SEED;
      data_shift        <= '0;
      pec_high_byte     <= '0;
      all_good          <= 1'b1;
      res_valid         <= 1'b0;
    end else begin
      if (fire) begin
        byte_position     <= byte_position_next;
        segment_count     <= segment_count_next;
        running_remainder <= running_remainder_next;
        data_shift        <= data_shift_next;
        pec_high_byte     <= pec_high_byte_next;
        all_good          <= all_good_next;
      end
      if (fire && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_data <= res_next;
    end
  end

  `ASSERT_IMPLY(a_seg_bound, clk, rst, 1'b1, segment_count <= SEG_W'(NUM_DEVICES), "segment count overran the chain length")
  `ASSERT_IMPLY(a_last_index, clk, rst, res_valid && res_data.last_segment, res_data.device_index == 3'(NUM_DEVICES - 1), "last segment flag on wrong device")
  `ASSERT_IMPLY(a_frame_ok, clk, rst, res_valid && res_data.frame_ok, res_data.pec_ok, "frame good while segment PEC failed")
  `ASSERT_NEXT(a_emit_shows, clk, rst, fire && emit, res_valid, "finished segment not presented")

endmodule

// File: hw/rtl/daisy_chain_pec15_readback_checker.sv
// ----------------------------------------------------------------------------
// daisy_chain_pec15_readback_checker
// Checks PEC-15 over each device segment of a daisy-chain readback frame.
// ----------------------------------------------------------------------------
// A result is registered once its final PEC byte leaves the input register.
// One byte per cycle (unrolled byte-wide PEC) while no result is waiting.
// Input register, then state update and result register in a single pass.
// Synchronous reset empties both registers and returns the segment state to
// its start values, the first byte after reset beginning a frame.
module daisy_chain_pec15_readback_checker
  import dcpc_pkg::*;
#(
  parameter int NUM_DEVICES = 2
)
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic held;
  in_t  held_data;
  logic trk_ready;

  assign in_ready = !held || trk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (trk_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

  dcpc_seg_tracker #(
    .NUM_DEVICES (NUM_DEVICES)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .item_valid (held),
    .item_ready (trk_ready),
    .item       (held_data),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_data   (out_data)
  );

endmodule
